// File: rtl/core/srts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the square ring tile scan.
// No dependencies; imported by every module of the block.
package srts_pkg;

    localparam int unsigned GRID_MAX = 1024;
    localparam int unsigned GW       = 11;   // grid register width
    localparam int unsigned CW       = 13;   // coordinate width
    localparam int unsigned RW       = 14;   // ring radius width, holds limit + 1
    localparam int unsigned OW       = 14;   // side offset width
    localparam int unsigned SW       = 16;   // seek arithmetic width
    localparam int unsigned AW       = 3;    // APB address width
    localparam int unsigned DW       = 32;   // APB data width

    localparam logic [GW-1:0] GRID_MAX_V = GW'(GRID_MAX);

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_NEXT  = 1'b1;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_LEFT   = 2'd3;

    typedef logic signed [SW-1:0] sval_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_INIT,
        ST_STEP,
        ST_SEEK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic init;
        logic step;
        logic idle_resp;
        logic seek;
    } cmd_t;

    typedef struct packed {
        logic is_next;
        logic clipped;
        logic active;
        logic seek_end;
    } status_t;

endpackage

// File: rtl/core/srts_regs.sv
`timescale 1ns / 1ps
// APB register file: grid width and height; the low GW bits of a write are saturated to GRID_MAX.
// Depends on srts_pkg.
module srts_regs (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [srts_pkg::AW-1:0]  paddr,
    input  logic [srts_pkg::DW-1:0]  pwdata,
    output logic [srts_pkg::DW-1:0]  prdata,
    output logic                     pready,
    output logic [srts_pkg::GW-1:0]  grid_width,
    output logic [srts_pkg::GW-1:0]  grid_height
);
    import srts_pkg::*;

    logic [GW-1:0] width_reg;
    logic [GW-1:0] height_reg;
    logic [GW-1:0] wdata_sat;
    logic          wr_en;

    assign wr_en     = psel & penable & pwrite;
    assign wdata_sat = (pwdata[GW-1:0] > GRID_MAX_V) ? GRID_MAX_V : pwdata[GW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= GW'(1);
            height_reg <= GW'(1);
        end else if (wr_en) begin
            if (paddr[2] == REG_GRID_WIDTH) begin
                width_reg <= wdata_sat;
            end else begin
                height_reg <= wdata_sat;
            end
        end
    end

    assign prdata      = (paddr[2] == REG_GRID_WIDTH) ? DW'(width_reg) : DW'(height_reg);
    assign pready      = 1'b1;
    assign grid_width  = width_reg;
    assign grid_height = height_reg;

endmodule

// File: rtl/core/srts_ctrl.sv
`timescale 1ns / 1ps
// Scan controller: sequences load, start setup, step and side-by-side seek.
// Depends on srts_pkg; drives the datapath through cmd_t.
module srts_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              s_mode,
    output srts_pkg::cmd_t    cmd,
    input  srts_pkg::status_t status
);
    import srts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_mode == MODE_NEXT) ? ST_STEP : ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = status.clipped ? ST_SEEK : ST_IDLE;
            end
            ST_STEP: begin
                if (status.active) begin
                    cmd.step   = 1'b1;
                    state_next = ST_SEEK;
                end else begin
                    cmd.idle_resp = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_SEEK: begin
                cmd.seek = 1'b1;
                if (status.seek_end) begin
                    state_next = status.is_next ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/srts_dpath.sv
`timescale 1ns / 1ps
// Scan datapath: latched word, ring position, one-side-per-cycle seek check
// and the result register. Depends on srts_pkg.
module srts_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  srts_pkg::cmd_t               cmd,
    output srts_pkg::status_t            status,
    input  logic [srts_pkg::GW-1:0]      grid_width,
    input  logic [srts_pkg::GW-1:0]      grid_height,
    input  logic                         s_mode,
    input  logic                         s_scan_kind,
    input  logic signed [srts_pkg::CW-1:0] s_center_col,
    input  logic signed [srts_pkg::CW-1:0] s_center_row,
    input  logic signed [srts_pkg::CW-1:0] s_vis_left,
    input  logic signed [srts_pkg::CW-1:0] s_vis_right,
    input  logic signed [srts_pkg::CW-1:0] s_vis_top,
    input  logic signed [srts_pkg::CW-1:0] s_vis_bottom,
    output logic signed [srts_pkg::CW-1:0] m_tile_col,
    output logic signed [srts_pkg::CW-1:0] m_tile_row,
    output logic                         m_is_last,
    output logic                         m_scan_done
);
    import srts_pkg::*;

    // latched input word
    logic                 mode_reg;
    logic                 kind_reg;
    logic signed [CW-1:0] in_cx_reg, in_cy_reg;
    logic signed [CW-1:0] vl_reg, vr_reg, vt_reg, vb_reg;

    // scan state
    logic                 clipped_reg;
    logic                 active_reg;
    logic                 pending_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [CW-1:0]        ri_reg, rj_reg;
    logic [CW-1:0]        lim_reg;
    logic [RW-1:0]        r_reg;
    logic [1:0]           side_reg;
    logic [OW-1:0]        off_reg;

    // result
    logic signed [CW-1:0] col_reg, row_reg;
    logic                 last_reg, done_reg;

    sval_t in_cx, in_cy, d_l, d_r, d_t, d_b, a_l, a_r, a_t, a_b;
    sval_t gw_s, gh_s, clamp_cx, clamp_cy;
    sval_t cx_s, cy_s, r_s, off_s, two_r, lim_s;
    sval_t lo_raw, hi_raw, lo_a, lo_b, hi_b;
    sval_t c_pt, w_pt, off_inc;
    logic  line_ok, hit, past_lim, wrap;

    assign in_cx = SW'(in_cx_reg);
    assign in_cy = SW'(in_cy_reg);
    assign gw_s  = sval_t'({5'b0, grid_width});
    assign gh_s  = sval_t'({5'b0, grid_height});
    assign d_l   = in_cx - SW'(vl_reg);
    assign d_r   = SW'(vr_reg) - in_cx;
    assign d_t   = in_cy - SW'(vt_reg);
    assign d_b   = SW'(vb_reg) - in_cy;
    assign a_l   = d_l[SW-1] ? -d_l : d_l;
    assign a_r   = d_r[SW-1] ? -d_r : d_r;
    assign a_t   = d_t[SW-1] ? -d_t : d_t;
    assign a_b   = d_b[SW-1] ? -d_b : d_b;

    assign clamp_cx = (in_cx > gw_s) ? gw_s : (in_cx[SW-1] ? '0 : in_cx);
    assign clamp_cy = (in_cy > gh_s) ? gh_s : (in_cy[SW-1] ? '0 : in_cy);

    assign cx_s  = SW'(cx_reg);
    assign cy_s  = SW'(cy_reg);
    assign r_s   = sval_t'({2'b0, r_reg});
    assign off_s = sval_t'({2'b0, off_reg});
    assign two_r = sval_t'({1'b0, r_reg, 1'b0});
    assign lim_s = sval_t'({3'b0, lim_reg});

    // clip the current side against the grid
    always_comb begin
        line_ok = 1'b0;
        lo_raw  = '0;
        hi_raw  = '0;
        c_pt    = '0;
        w_pt    = '0;
        case (side_reg)
            SIDE_TOP: begin
                line_ok = ((cy_s - r_s) >= 0) && ((cy_s - r_s) < gh_s);
                lo_raw  = r_s - cx_s;
                hi_raw  = gw_s - sval_t'(1) + r_s - cx_s;
                c_pt    = cx_s - r_s + off_s;
                w_pt    = cy_s - r_s;
            end
            SIDE_RIGHT: begin
                line_ok = ((cx_s + r_s) >= 0) && ((cx_s + r_s) < gw_s);
                lo_raw  = r_s - cy_s;
                hi_raw  = gh_s - sval_t'(1) + r_s - cy_s;
                c_pt    = cx_s + r_s;
                w_pt    = cy_s - r_s + off_s;
            end
            SIDE_BOTTOM: begin
                line_ok = ((cy_s + r_s) >= 0) && ((cy_s + r_s) < gh_s);
                lo_raw  = cx_s + r_s - (gw_s - sval_t'(1));
                hi_raw  = cx_s + r_s;
                c_pt    = cx_s + r_s - off_s;
                w_pt    = cy_s + r_s;
            end
            SIDE_LEFT: begin
                line_ok = ((cx_s - r_s) >= 0) && ((cx_s - r_s) < gw_s);
                lo_raw  = cy_s + r_s - (gh_s - sval_t'(1));
                hi_raw  = cy_s + r_s;
                c_pt    = cx_s - r_s;
                w_pt    = cy_s + r_s - off_s;
            end
            default: begin
                line_ok = 1'b0;
            end
        endcase
    end

    assign lo_a     = (lo_raw > off_s) ? lo_raw : off_s;
    assign lo_b     = lo_a[SW-1] ? '0 : lo_a;
    assign hi_b     = (hi_raw < two_r) ? hi_raw : two_r;
    assign hit      = line_ok && (lo_b <= hi_b);
    assign past_lim = r_s > lim_s;
    assign off_inc  = off_s + sval_t'(1);
    assign wrap     = off_inc > two_r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clipped_reg <= 1'b0;
            active_reg  <= 1'b0;
            pending_reg <= 1'b0;
            mode_reg    <= MODE_START;
            r_reg       <= '0;
            side_reg    <= SIDE_TOP;
            off_reg     <= '0;
            lim_reg     <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
        end else begin
            if (cmd.load) begin
                mode_reg <= s_mode;
                if (s_mode == MODE_START) begin
                    clipped_reg <= s_scan_kind;
                end
            end
            if (cmd.prep) begin
                cx_reg <= clipped_reg ? in_cx_reg : clamp_cx[CW-1:0];
                cy_reg <= clipped_reg ? in_cy_reg : clamp_cy[CW-1:0];
            end
            if (cmd.init) begin
                if (clipped_reg) begin
                    lim_reg <= (ri_reg > rj_reg) ? ri_reg : rj_reg;
                    r_reg   <= '0;
                end else begin
                    lim_reg <= CW'((grid_width > grid_height) ? grid_width : grid_height);
                    r_reg   <= RW'(1);
                end
                side_reg    <= SIDE_TOP;
                off_reg     <= '0;
                pending_reg <= !clipped_reg;
                active_reg  <= 1'b1;
            end
            if (cmd.step) begin
                if (pending_reg) begin
                    pending_reg <= 1'b0;
                end else if (wrap) begin
                    off_reg <= '0;
                    if (side_reg == SIDE_LEFT) begin
                        side_reg <= SIDE_TOP;
                        r_reg    <= r_reg + RW'(1);
                    end else begin
                        side_reg <= side_reg + 2'd1;
                    end
                end else begin
                    off_reg <= off_inc[OW-1:0];
                end
            end
            if (cmd.seek) begin
                if (past_lim) begin
                    active_reg <= 1'b0;
                end else if (!clipped_reg) begin
                    active_reg <= 1'b1;
                end else if (hit) begin
                    off_reg <= lo_b[OW-1:0];
                end else begin
                    off_reg <= '0;
                    if (side_reg == SIDE_LEFT) begin
                        side_reg <= SIDE_TOP;
                        r_reg    <= r_reg + RW'(1);
                    end else begin
                        side_reg <= side_reg + 2'd1;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= s_scan_kind;
            in_cx_reg <= s_center_col;
            in_cy_reg <= s_center_row;
            vl_reg    <= s_vis_left;
            vr_reg    <= s_vis_right;
            vt_reg    <= s_vis_top;
            vb_reg    <= s_vis_bottom;
        end
        if (cmd.prep) begin
            ri_reg <= (a_l > a_r) ? a_l[CW-1:0] : a_r[CW-1:0];
            rj_reg <= (a_t > a_b) ? a_t[CW-1:0] : a_b[CW-1:0];
        end
        if (cmd.idle_resp) begin
            col_reg  <= '0;
            row_reg  <= '0;
            last_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        if (cmd.step) begin
            col_reg  <= pending_reg ? cx_reg : c_pt[CW-1:0];
            row_reg  <= pending_reg ? cy_reg : w_pt[CW-1:0];
            done_reg <= 1'b0;
        end
        if (cmd.seek) begin
            last_reg <= past_lim;
        end
    end

    assign status.is_next  = mode_reg;
    assign status.clipped  = (cmd.init | cmd.prep) ? kind_reg : clipped_reg;
    assign status.active   = active_reg;
    assign status.seek_end = past_lim | !clipped_reg | hit;

    assign m_tile_col  = col_reg;
    assign m_tile_row  = row_reg;
    assign m_is_last   = last_reg;
    assign m_scan_done = done_reg;

endmodule

// File: rtl/core/square_ring_tile_scan.sv
`timescale 1ns / 1ps
// Top level of the square ring tile scan: registers, controller, datapath.
// Depends on srts_pkg, srts_regs, srts_ctrl and srts_dpath.
//
//   channel  | ports               | moves
//   ---------+---------------------+-----------------------------------
//   input    | s_valid / s_ready   | start or next request word
//   result   | m_valid / m_ready   | tile index or done word
//   config   | psel..pready (APB)  | grid_width @0x0, grid_height @0x4
//
// One word at a time. Start: load, prep and init, then for a clipped scan a
// seek to the first visible ring side. Next: a step and a seek over the ring
// sides, or a done word once the scan has ended; the result then waits in the
// output register until taken. The seek sequencer checks one ring side per cycle.
// Reset (aresetn low, synchronous) drops any scan; grid registers return to 1.
module square_ring_tile_scan (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srts_pkg::AW-1:0]      paddr,
    input  logic [srts_pkg::DW-1:0]      pwdata,
    output logic [srts_pkg::DW-1:0]      prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic                         s_scan_kind,
    input  logic signed [srts_pkg::CW-1:0] s_center_col,
    input  logic signed [srts_pkg::CW-1:0] s_center_row,
    input  logic signed [srts_pkg::CW-1:0] s_vis_left,
    input  logic signed [srts_pkg::CW-1:0] s_vis_right,
    input  logic signed [srts_pkg::CW-1:0] s_vis_top,
    input  logic signed [srts_pkg::CW-1:0] s_vis_bottom,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [srts_pkg::CW-1:0] m_tile_col,
    output logic signed [srts_pkg::CW-1:0] m_tile_row,
    output logic                         m_is_last,
    output logic                         m_scan_done
);
    import srts_pkg::*;

    logic [GW-1:0] grid_width;
    logic [GW-1:0] grid_height;
    cmd_t          cmd;
    status_t       status;

    srts_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .grid_width  (grid_width),
        .grid_height (grid_height)
    );

    srts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .s_mode  (s_mode),
        .cmd     (cmd),
        .status  (status)
    );

    srts_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .grid_width   (grid_width),
        .grid_height  (grid_height),
        .s_mode       (s_mode),
        .s_scan_kind  (s_scan_kind),
        .s_center_col (s_center_col),
        .s_center_row (s_center_row),
        .s_vis_left   (s_vis_left),
        .s_vis_right  (s_vis_right),
        .s_vis_top    (s_vis_top),
        .s_vis_bottom (s_vis_bottom),
        .m_tile_col   (m_tile_col),
        .m_tile_row   (m_tile_row),
        .m_is_last    (m_is_last),
        .m_scan_done  (m_scan_done)
    );

endmodule

// File: rtl/core/srts_chk.sv
`timescale 1ns / 1ps
// Port-level checks of the square ring tile scan, bound to the top level.
// Depends on srts_pkg and square_ring_tile_scan.
module srts_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [srts_pkg::CW-1:0] m_tile_col,
    input logic signed [srts_pkg::CW-1:0] m_tile_row,
    input logic                         m_is_last,
    input logic                         m_scan_done
);
    import srts_pkg::*;

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tile_col) && $stable(m_tile_row)
            && $stable(m_is_last) && $stable(m_scan_done))
        else $error("result word changed while stalled");

    a_done_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scan_done |-> m_tile_col == '0 && m_tile_row == '0 && !m_is_last)
        else $error("done word carries tile data");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("no work cycle after an accepted word");

endmodule

bind square_ring_tile_scan srts_chk u_chk (.*);

// File: test/srts_tb_pkg.sv
`timescale 1ns / 1ps
// Word types and the tile order tracker for the square ring tile scan bench.
// Depends on srts_pkg; the tracker predicts tile words and checks them.
package srts_tb_pkg;
    import srts_pkg::*;

    typedef struct packed {
        logic                 mode;
        logic                 scan_kind;
        logic signed [CW-1:0] center_col;
        logic signed [CW-1:0] center_row;
        logic signed [CW-1:0] vis_left;
        logic signed [CW-1:0] vis_right;
        logic signed [CW-1:0] vis_top;
        logic signed [CW-1:0] vis_bottom;
    } scan_req_t;

    typedef struct packed {
        logic signed [CW-1:0] col;
        logic signed [CW-1:0] row;
        logic                 is_last;
        logic                 scan_done;
    } tile_word_t;

    class tile_order_tracker;
        logic [GW-1:0] grid_w;
        logic [GW-1:0] grid_h;
        longint        ring_r;
        longint        ring_lim;
        longint        ring_off;
        logic [1:0]    ring_side;
        longint        ctr_col;
        longint        ctr_row;
        bit            clipped;
        bit            center_due;
        bit            scanning;
        longint        walk_r;
        longint        walk_off;
        logic [1:0]    walk_side;
        tile_word_t    expected_tiles[$];
        int            errors;

        function new();
            grid_w     = 1;
            grid_h     = 1;
            ring_r     = 0;
            ring_lim   = 0;
            ring_off   = 0;
            ring_side  = SIDE_TOP;
            ctr_col    = 0;
            ctr_row    = 0;
            clipped    = 1'b0;
            center_due = 1'b0;
            scanning   = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_tiles.size();
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // advance the walk position to the next point to emit
        function bit find_visible();
            longint gw;
            longint gh;
            longint rr;
            longint lo;
            longint hi;
            bit     line_ok;
            gw = grid_w;
            gh = grid_h;
            while (walk_r <= ring_lim) begin
                if (!clipped)
                    return 1'b1;
                rr = walk_r;
                case (walk_side)
                    SIDE_TOP: begin
                        line_ok = (ctr_row - rr >= 0) && (ctr_row - rr < gh);
                        lo = rr - ctr_col;
                        hi = gw - 1 + rr - ctr_col;
                    end
                    SIDE_RIGHT: begin
                        line_ok = (ctr_col + rr >= 0) && (ctr_col + rr < gw);
                        lo = rr - ctr_row;
                        hi = gh - 1 + rr - ctr_row;
                    end
                    SIDE_BOTTOM: begin
                        line_ok = (ctr_row + rr >= 0) && (ctr_row + rr < gh);
                        lo = ctr_col + rr - (gw - 1);
                        hi = ctr_col + rr;
                    end
                    default: begin
                        line_ok = (ctr_col - rr >= 0) && (ctr_col - rr < gw);
                        lo = ctr_row + rr - (gh - 1);
                        hi = ctr_row + rr;
                    end
                endcase
                if (walk_off > lo)
                    lo = walk_off;
                if (lo < 0)
                    lo = 0;
                if (hi > 2 * rr)
                    hi = 2 * rr;
                if (line_ok && lo <= hi) begin
                    walk_off = lo;
                    return 1'b1;
                end
                walk_off = 0;
                if (walk_side == SIDE_LEFT) begin
                    walk_side = SIDE_TOP;
                    walk_r++;
                end else begin
                    walk_side = walk_side + 2'd1;
                end
            end
            return 1'b0;
        endfunction

        function void note_grid_write(logic idx, logic [DW-1:0] data);
            logic [GW-1:0] v;
            v = data[GW-1:0];
            if (v > GRID_MAX_V)
                v = GRID_MAX_V;
            if (idx == REG_GRID_WIDTH)
                grid_w = v;
            else
                grid_h = v;
        endfunction

        function void check_grid_read(logic idx, logic [DW-1:0] got);
            logic [DW-1:0] want;
            want = DW'((idx == REG_GRID_WIDTH) ? grid_w : grid_h);
            if (got !== want) begin
                $display("%0t: grid register %0d read expected %0d, got %0d",
                         $time, idx, want, got);
                errors++;
            end
        endfunction

        function void note_request(scan_req_t req);
            longint     cx;
            longint     cy;
            longint     reach;
            longint     c;
            longint     w;
            bit         more;
            tile_word_t t;
            cx = $signed(req.center_col);
            cy = $signed(req.center_row);
            if (req.mode == MODE_START) begin
                clipped = req.scan_kind;
                if (!clipped) begin
                    if (cx > longint'(grid_w))
                        cx = grid_w;
                    else if (cx < 0)
                        cx = 0;
                    if (cy > longint'(grid_h))
                        cy = grid_h;
                    else if (cy < 0)
                        cy = 0;
                    ring_lim   = (grid_w > grid_h) ? grid_w : grid_h;
                    center_due = 1'b1;
                    ring_r     = 1;
                    ring_side  = SIDE_TOP;
                    ring_off   = 0;
                    ctr_col    = cx;
                    ctr_row    = cy;
                    scanning   = 1'b1;
                end else begin
                    reach = mag(cx - $signed(req.vis_left));
                    if (mag($signed(req.vis_right) - cx) > reach)
                        reach = mag($signed(req.vis_right) - cx);
                    if (mag(cy - $signed(req.vis_top)) > reach)
                        reach = mag(cy - $signed(req.vis_top));
                    if (mag($signed(req.vis_bottom) - cy) > reach)
                        reach = mag($signed(req.vis_bottom) - cy);
                    ring_lim   = reach;
                    center_due = 1'b0;
                    ctr_col    = cx;
                    ctr_row    = cy;
                    walk_r     = 0;
                    walk_side  = SIDE_TOP;
                    walk_off   = 0;
                    scanning   = find_visible();
                    ring_r     = scanning ? walk_r : 0;
                    ring_side  = scanning ? walk_side : SIDE_TOP;
                    ring_off   = scanning ? walk_off : 0;
                end
                return;
            end
            if (!scanning) begin
                t.col       = '0;
                t.row       = '0;
                t.is_last   = 1'b0;
                t.scan_done = 1'b1;
                expected_tiles.insert(expected_tiles.size(), t);
                return;
            end
            walk_r    = ring_r;
            walk_side = ring_side;
            walk_off  = ring_off;
            if (center_due) begin
                c = ctr_col;
                w = ctr_row;
                center_due = 1'b0;
            end else begin
                case (walk_side)
                    SIDE_TOP: begin
                        c = ctr_col - walk_r + walk_off;
                        w = ctr_row - walk_r;
                    end
                    SIDE_RIGHT: begin
                        c = ctr_col + walk_r;
                        w = ctr_row - walk_r + walk_off;
                    end
                    SIDE_BOTTOM: begin
                        c = ctr_col + walk_r - walk_off;
                        w = ctr_row + walk_r;
                    end
                    default: begin
                        c = ctr_col - walk_r;
                        w = ctr_row + walk_r - walk_off;
                    end
                endcase
                walk_off++;
                if (walk_off > 2 * walk_r) begin
                    walk_off = 0;
                    if (walk_side == SIDE_LEFT) begin
                        walk_side = SIDE_TOP;
                        walk_r++;
                    end else begin
                        walk_side = walk_side + 2'd1;
                    end
                end
            end
            more = find_visible();
            if (more) begin
                ring_r    = walk_r;
                ring_side = walk_side;
                ring_off  = walk_off;
            end else begin
                scanning = 1'b0;
            end
            t.col       = c[CW-1:0];
            t.row       = w[CW-1:0];
            t.is_last   = !more;
            t.scan_done = 1'b0;
            expected_tiles.insert(expected_tiles.size(), t);
        endfunction

        function void check_tile(input logic signed [CW-1:0] col, row,
                                 input logic last, done);
            tile_word_t want;
            if (expected_tiles.size() == 0) begin
                $display("%0t: result word with none expected: col %0d row %0d last %0b done %0b",
                         $time, col, row, last, done);
                errors++;
                return;
            end
            want = expected_tiles.pop_front();
            if (col !== want.col) begin
                $display("%0t: tile_col expected %0d, got %0d", $time, want.col, col);
                errors++;
            end
            if (row !== want.row) begin
                $display("%0t: tile_row expected %0d, got %0d", $time, want.row, row);
                errors++;
            end
            if (last !== want.is_last) begin
                $display("%0t: is_last expected %0b, got %0b", $time, want.is_last, last);
                errors++;
            end
            if (done !== want.scan_done) begin
                $display("%0t: scan_done expected %0b, got %0b", $time, want.scan_done, done);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: test/tb.sv
`timescale 1ns / 1ps
// Bench top for square_ring_tile_scan: bursty start and next words, a stalling
// result side and grid reprogramming over APB, every word checked in order.
// Depends on srts_pkg, srts_tb_pkg and the square_ring_tile_scan RTL.
module tb;
    import srts_pkg::*;
    import srts_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 5_000_000;
    localparam int          PHASE_WORDS   = 127;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          PHASES        = 12;
    localparam int          PHASE_W [PHASES] = '{3, 1024, 0, 2047, 1, 5, 2, 8, 4, 1024, 6, 2};
    localparam int          PHASE_H [PHASES] = '{2, 1024, 5, 1, 2000, 7, 0, 3, 4, 6, 1, 9};

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} rdy_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AW-1:0]        paddr;
    logic [DW-1:0]        pwdata;
    logic [DW-1:0]        prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_mode;
    logic                 s_scan_kind;
    logic signed [CW-1:0] s_center_col;
    logic signed [CW-1:0] s_center_row;
    logic signed [CW-1:0] s_vis_left;
    logic signed [CW-1:0] s_vis_right;
    logic signed [CW-1:0] s_vis_top;
    logic signed [CW-1:0] s_vis_bottom;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [CW-1:0] m_tile_col;
    logic signed [CW-1:0] m_tile_row;
    logic                 m_is_last;
    logic                 m_scan_done;

    tile_order_tracker tracker;
    int unsigned       cycle_count = 0;
    int                burst_left;
    bit                hold_req;

    square_ring_tile_scan dut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic scan_req_t random_next();
        scan_req_t r;
        r.mode       = MODE_NEXT;
        r.scan_kind  = 1'($urandom);
        r.center_col = CW'($urandom);
        r.center_row = CW'($urandom);
        r.vis_left   = CW'($urandom);
        r.vis_right  = CW'($urandom);
        r.vis_top    = CW'($urandom);
        r.vis_bottom = CW'($urandom);
        return r;
    endfunction

    function automatic scan_req_t start_word(logic kind, int cc, int cr,
                                             int vl, int vr, int vt, int vb);
        scan_req_t r;
        r.mode       = MODE_START;
        r.scan_kind  = kind;
        r.center_col = CW'(cc);
        r.center_row = CW'(cr);
        r.vis_left   = CW'(vl);
        r.vis_right  = CW'(vr);
        r.vis_top    = CW'(vt);
        r.vis_bottom = CW'(vb);
        return r;
    endfunction

    // keep most centers near the grid and bounds close, some fully random
    function automatic scan_req_t random_start();
        scan_req_t r;
        longint    cx;
        longint    cy;
        r = random_next();
        r.mode = MODE_START;
        if ($urandom_range(0, 15) != 0) begin
            cx = longint'($urandom_range(0, int'(tracker.grid_w) + 8)) - 4;
            cy = longint'($urandom_range(0, int'(tracker.grid_h) + 8)) - 4;
            r.center_col = CW'(cx);
            r.center_row = CW'(cy);
            r.vis_left   = CW'(cx - longint'($urandom_range(0, 6)));
            r.vis_right  = CW'(cx + longint'($urandom_range(0, 6)));
            r.vis_top    = CW'(cy - longint'($urandom_range(0, 6)));
            r.vis_bottom = CW'(cy + longint'($urandom_range(0, 6)));
        end
        return r;
    endfunction

    task automatic send_word(input scan_req_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_mode       <= w.mode;
        s_scan_kind  <= w.scan_kind;
        s_center_col <= w.center_col;
        s_center_row <= w.center_row;
        s_vis_left   <= w.vis_left;
        s_vis_right  <= w.vis_right;
        s_vis_top    <= w.vis_top;
        s_vis_bottom <= w.vis_bottom;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(w);
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic settle();
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [GW-1:0] value);
        logic [DW-1:0] data;
        data = {(DW-GW)'($urandom), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'({idx, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.note_grid_write(idx, data);
    endtask

    task automatic apb_read(input logic idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AW'({idx, 2'b00});
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.check_grid_read(idx, prdata);
    endtask

    task automatic program_grid(input int w, input int h);
        apb_write(REG_GRID_WIDTH, GW'(w));
        apb_write(REG_GRID_HEIGHT, GW'(h));
        apb_read(REG_GRID_WIDTH);
        apb_read(REG_GRID_HEIGHT);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_directed();
        send_word(random_next());
        send_word(start_word(1'b0, -4096, 4095, -4096, 4095, -4096, 4095));
        repeat (14) send_word(random_next());
        send_word(start_word(1'b1, 4095, -4096, -4096, 4095, 4095, -4096));
        send_word(random_next());
        send_word(start_word(1'b1, 0, 0, 0, 0, 0, 0));
        repeat (5) send_word(random_next());
        send_word(start_word(1'b1, 100, 100, 100, 100, 100, 100));
        send_word(random_next());
        end_burst();
    endtask

    // open with nexts that continue the previous scan under the new grid
    task automatic run_phase(input int words);
        int sent;
        int k;
        sent = 0;
        repeat ($urandom_range(1, 6)) begin
            send_word(random_next());
            sent++;
        end
        while (sent < words) begin
            if ($urandom_range(0, 11) == 0) begin
                send_word(random_next());
                sent++;
            end else begin
                send_word(random_start());
                sent++;
                case ($urandom_range(0, 9))
                    0:       k = 0;
                    1, 2, 3: k = $urandom_range(20, 60);
                    4:       k = $urandom_range(100, 200);
                    default: k = $urandom_range(1, 20);
                endcase
                if (k > words - sent)
                    k = words - sent;
                repeat (k) begin
                    send_word(random_next());
                    sent++;
                end
            end
        end
        send_word(random_start());
        send_word(random_next());
        end_burst();
    endtask

    initial begin
        tracker = new();
        hold_req = 1'b0;
        burst_left = 0;
        aresetn      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        s_valid      <= 1'b0;
        s_mode       <= MODE_NEXT;
        s_scan_kind  <= 1'b0;
        s_center_col <= '0;
        s_center_row <= '0;
        s_vis_left   <= '0;
        s_vis_right  <= '0;
        s_vis_top    <= '0;
        s_vis_bottom <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            program_grid(PHASE_W[ph], PHASE_H[ph]);
            if (ph == 0)
                hold_req = 1'b1;
            run_phase(PHASE_WORDS);
        end
        settle();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("square_ring_tile_scan regression: pass");
        end else begin
            $display("square_ring_tile_scan regression: fail");
        end
        $finish;
    end

    initial begin
        rdy_mode_t rdy_mode;
        int        mode_left;
        int        hold_left;
        int        tick;
        rdy_mode  = RDY_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rdy_mode)
                    RDY_ALWAYS: m_ready <= 1'b1;
                    RDY_COIN:   m_ready <= 1'($urandom);
                    RDY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:    m_ready <= ((tick % 6) < 3);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_tile(m_tile_col, m_tile_row, m_is_last, m_scan_done);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("square_ring_tile_scan regression: fail");
            $finish;
        end
    end

endmodule
